// ===== sv/smc_pkg.sv =====
`default_nettype none
package smc_pkg;

    // sample and accumulator widths
    localparam int SMP_W = 16;
    localparam int LR_W  = 43;
    localparam int MS_W  = 45;
    localparam int X_W   = 44;

    // shared multi-cycle multiplier: operand and product widths
    localparam int MUL_W  = 48;
    localparam int MULP_W = 2 * MUL_W;
    localparam int HALF_W = MUL_W / 2;

    // root search unit: word width, divisor operand width, quotient width
    localparam int RW   = 121;
    localparam int RD_W = 88;
    localparam int RQ_W = 32;

    // divider widths
    localparam int DV_W  = 48;
    localparam int DEN_W = 33;

    // width scaling and limits
    localparam logic [15:0] W_MAX = 16'd36045;
    localparam logic [15:0] K072  = 16'd47186;

    // root search start bits
    localparam logic [4:0] TOP_16 = 5'd15;
    localparam logic [4:0] TOP_32 = 5'd31;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NONE,
        DP_SQ_L,
        DP_SQ_R,
        DP_CROSS,
        DP_ACC,
        DP_MUL_D,
        DP_MUL_N,
        DP_ROOT_C,
        DP_ROOT_U,
        DP_ROOT_T,
        DP_ROOT_A,
        DP_ROOT_B,
        DP_DIV,
        DP_WIDTH,
        DP_FINISH
    } dp_op_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_SQ_R,
        ST_CROSS,
        ST_ACC,
        ST_MUL_D,
        ST_MUL_D_W,
        ST_MUL_N,
        ST_MUL_N_W,
        ST_ROOT_C,
        ST_ROOT_C_W,
        ST_ROOT_U,
        ST_ROOT_U_W,
        ST_ROOT_T,
        ST_ROOT_T_W,
        ST_ROOT_A,
        ST_ROOT_A_W,
        ST_ROOT_B,
        ST_ROOT_B_W,
        ST_DIV,
        ST_DIV_W,
        ST_WIDTH,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   start;
        logic   load;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic last;
        logic out_full;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/smc_mul.sv =====
`default_nettype none
module smc_mul import smc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [MULP_W-1:0] p
);

    logic [MUL_W-1:0]  a_reg, b_reg;
    logic [MULP_W-1:0] acc_reg;
    logic [1:0]        idx_reg;
    logic              busy_reg, done_reg;
    logic [HALF_W-1:0] a_half, b_half;
    logic [MUL_W-1:0]  pp;
    logic [MULP_W-1:0] pp_sh;

    // one partial product per cycle
    always_comb
    begin
        a_half = idx_reg[1] ? a_reg[MUL_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = idx_reg[0] ? b_reg[MUL_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp     = MUL_W'(a_half) * MUL_W'(b_half);
        unique case (idx_reg)
            2'd0:    pp_sh = MULP_W'(pp);
            2'd3:    pp_sh = MULP_W'(pp) << (2 * HALF_W);
            default: pp_sh = MULP_W'(pp) << HALF_W;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (idx_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

// ===== sv/smc_root.sv =====
`default_nettype none
module smc_root import smc_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RD_W-1:0] d,
    input  logic [RW-1:0]   n,
    input  logic [4:0]      top,
    output logic            done,
    output logic [RQ_W-1:0] q
);

    // finds the largest q with q*q*d <= n, one bit per cycle from the top
    // s = q^2*d, f = q*d << (k+1), e = d << 2k
    logic [RW-1:0]   s_reg, f_reg, e_reg, n_reg;
    logic [RQ_W-1:0] q_reg;
    logic [4:0]      k_reg;
    logic            busy_reg, done_reg;
    logic [RW-1:0]   trial;
    logic [RW:0]     fe;

    always_comb
    begin
        trial = s_reg + f_reg + e_reg;
        fe    = {1'b0, f_reg} + {e_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= top;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 5'd1;
                if (k_reg == 5'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

    // search registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg <= '0;
            f_reg <= '0;
            e_reg <= RW'(d) << {top, 1'b0};
            n_reg <= n;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial <= n_reg)
            begin
                s_reg <= trial;
                f_reg <= fe[RW:1];
                q_reg <= q_reg | (RQ_W'(1) << k_reg);
            end
            else
                f_reg <= f_reg >> 1;
            e_reg <= e_reg >> 2;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

// ===== sv/smc_div.sv =====
`default_nettype none
module smc_div import smc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DV_W-1:0]  num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [15:0]      q
);

    // restoring division, 16 quotient bits, one per cycle
    logic [DV_W-1:0] r_reg, dsh_reg;
    logic [15:0]     q_reg;
    logic [3:0]      k_reg;
    logic            busy_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == 4'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 4'd15;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 4'd1;
                if (k_reg == 4'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= num;
            dsh_reg <= DV_W'(den) << 15;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (r_reg >= dsh_reg)
            begin
                r_reg <= r_reg - dsh_reg;
                q_reg <= q_reg | (16'd1 << k_reg);
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

// ===== sv/smc_datapath.sv =====
`default_nettype none
module smc_datapath import smc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic signed [SMP_W-1:0]  left_sample,
    input  logic signed [SMP_W-1:0]  right_sample,
    input  logic                     last_in_frame,
    input  logic                     out_ready,
    output dp_status_t               status,
    output logic                     out_valid,
    output logic [15:0]              stereo_width,
    output logic signed [15:0]       correlation,
    output logic [15:0]              phase_stability,
    output logic signed [15:0]       pan
);

    // input item
    logic signed [SMP_W-1:0] l_reg, r_reg;
    logic                    last_reg;

    // sample products
    logic signed [SMP_W-1:0] ma, mb;
    logic signed [31:0]      prod_reg;
    logic [30:0]             pl_reg, pr_reg;

    // accumulators
    logic [LR_W-1:0]        le_reg, re_reg;
    logic [MS_W-1:0]        mid_reg, side_reg;
    logic signed [X_W-1:0]  x_reg;

    // frame-end intermediates
    logic [85:0]            lr_reg;
    logic [86:0]            xsq_reg;
    logic signed [15:0]     c_reg;
    logic [15:0]            u_reg, t_reg;
    logic [RQ_W-1:0]        a_reg, b_reg;
    logic [15:0]            w_reg;
    logic signed [15:0]     p_reg;

    // outputs
    logic                   out_valid_reg;
    logic [15:0]            ow_reg, oph_reg;
    logic signed [15:0]     oc_reg, op_reg;

    // units
    logic              mul_start, root_start, div_start;
    logic              mul_done, root_done, div_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [MULP_W-1:0] mul_p;
    logic [RD_W-1:0]   root_d;
    logic [RW-1:0]     root_n;
    logic [4:0]        root_top;
    logic [RQ_W-1:0]   root_q;
    logic [DV_W-1:0]   div_num;
    logic [DEN_W-1:0]  div_den;
    logic [15:0]       div_q;
    logic              capture;

    // accumulate helpers
    logic [LR_W:0]        le_sum, re_sum;
    logic [33:0]          sq_sum, plr2, mid_t, side_t;
    logic [MS_W:0]        mid_sum, side_sum;
    logic signed [X_W:0]  x_sum;
    logic [X_W-1:0]       x_abs;

    // frame-end helpers
    logic               zero_lr, x_neg, pan_neg;
    logic [15:0]        q16, phase_c;
    logic signed [15:0] c_val, p_val;
    logic [16:0]        u_arg;
    logic [RQ_W-1:0]    lvl_diff;
    logic [15:0]        p_mag, t_eff;
    logic [16:0]        tu_sum;
    logic [32:0]        w_prod;
    logic [16:0]        w_raw;
    logic               w_full;
    logic [15:0]        w_val;

    // sample multiplier operands
    always_comb
    begin
        ma = (cmd.op == DP_SQ_R) ? r_reg : l_reg;
        mb = (cmd.op == DP_SQ_L) ? l_reg : r_reg;
    end

    // saturating sums
    always_comb
    begin
        le_sum   = {1'b0, le_reg} + (LR_W+1)'(prod_reg[30:0]);
        re_sum   = {1'b0, re_reg} + (LR_W+1)'(prod_reg[30:0]);
        sq_sum   = {3'b000, pl_reg} + {3'b000, pr_reg};
        plr2     = {prod_reg[31], prod_reg, 1'b0};
        mid_t    = sq_sum + plr2;
        side_t   = sq_sum - plr2;
        mid_sum  = {1'b0, mid_reg} + (MS_W+1)'(mid_t[32:0]);
        side_sum = {1'b0, side_reg} + (MS_W+1)'(side_t[32:0]);
        x_sum    = {x_reg[X_W-1], x_reg} + {{(X_W-31){prod_reg[31]}}, prod_reg};
        x_abs    = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
    end

    // unit operand selection
    always_comb
    begin
        mul_start  = cmd.start && (cmd.op == DP_MUL_D || cmd.op == DP_MUL_N);
        root_start = cmd.start && (cmd.op == DP_ROOT_C || cmd.op == DP_ROOT_U ||
                                   cmd.op == DP_ROOT_T || cmd.op == DP_ROOT_A ||
                                   cmd.op == DP_ROOT_B);
        div_start  = cmd.start && (cmd.op == DP_DIV);
        capture    = !cmd.start && (mul_done || root_done || div_done);

        mul_a = (cmd.op == DP_MUL_D) ? MUL_W'(le_reg) : MUL_W'(x_abs);
        mul_b = (cmd.op == DP_MUL_D) ? MUL_W'(re_reg) : MUL_W'(x_abs);

        phase_c = {~c_reg[15], c_reg[14:0]};
        u_arg   = 17'h10000 - {1'b0, phase_c};

        root_top = TOP_16;
        root_d   = RD_W'(1);
        root_n   = '0;
        unique case (cmd.op)
            DP_ROOT_C:
            begin
                root_d = RD_W'(lr_reg);
                root_n = RW'(xsq_reg) << 30;
            end
            DP_ROOT_U:
                root_n = RW'(u_arg) << 13;
            DP_ROOT_T:
            begin
                root_d = RD_W'(mid_reg);
                root_n = RW'(side_reg) << 28;
            end
            DP_ROOT_A:
            begin
                root_top = TOP_32;
                root_n   = RW'(le_reg) << 20;
            end
            DP_ROOT_B:
            begin
                root_top = TOP_32;
                root_n   = RW'(re_reg) << 20;
            end
            default:
                root_n = '0;
        endcase

        pan_neg  = b_reg < a_reg;
        lvl_diff = pan_neg ? (a_reg - b_reg) : (b_reg - a_reg);
        div_num  = DV_W'(lvl_diff) << 15;
        div_den  = {1'b0, a_reg} + {1'b0, b_reg};
    end

    // correlation, pan and width results
    always_comb
    begin
        zero_lr = (le_reg == '0) || (re_reg == '0);
        x_neg   = x_reg[X_W-1];
        q16     = root_q[15:0];
        if (zero_lr)
            c_val = '0;
        else if (x_neg)
            c_val = q16[15] ? 16'sh8000 : $signed(16'(17'd0 - {2'b00, q16[14:0]}));
        else
            c_val = q16[15] ? 16'sh7FFF : $signed(q16);

        p_mag = div_q[15] ? 16'h7FFF : div_q;
        if (div_den == '0)
            p_val = '0;
        else if (pan_neg)
            p_val = $signed(16'(17'd0 - {1'b0, p_mag}));
        else
            p_val = $signed(p_mag);

        t_eff  = (mid_reg == '0) ? 16'd0 : t_reg;
        tu_sum = {1'b0, t_eff} + {1'b0, u_reg};
        w_prod = 33'(K072) * 33'(tu_sum);
        w_raw  = w_prod[32:16];
        w_full = ((mid_reg == '0) && (side_reg != '0)) ||
                 ((mid_reg != '0) && ({4'b0000, side_reg} >= {mid_reg, 4'b0000}));
        if (w_full || (w_raw > 17'(W_MAX)))
            w_val = W_MAX;
        else
            w_val = w_raw[15:0];
    end

    // input item and per-item products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else if (cmd.load)
            last_reg <= last_in_frame;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg <= left_sample;
            r_reg <= right_sample;
        end
        if (cmd.op == DP_SQ_L || cmd.op == DP_SQ_R || cmd.op == DP_CROSS)
            prod_reg <= ma * mb;
        if (cmd.op == DP_SQ_R)
            pl_reg <= prod_reg[30:0];
        if (cmd.op == DP_CROSS)
            pr_reg <= prod_reg[30:0];
    end

    // frame accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg   <= '0;
            re_reg   <= '0;
            mid_reg  <= '0;
            side_reg <= '0;
            x_reg    <= '0;
        end
        else if (cmd.op == DP_FINISH)
        begin
            le_reg   <= '0;
            re_reg   <= '0;
            mid_reg  <= '0;
            side_reg <= '0;
            x_reg    <= '0;
        end
        else if (cmd.op == DP_SQ_R)
            le_reg <= le_sum[LR_W] ? '1 : le_sum[LR_W-1:0];
        else if (cmd.op == DP_CROSS)
            re_reg <= re_sum[LR_W] ? '1 : re_sum[LR_W-1:0];
        else if (cmd.op == DP_ACC)
        begin
            mid_reg  <= mid_sum[MS_W] ? '1 : mid_sum[MS_W-1:0];
            side_reg <= side_sum[MS_W] ? '1 : side_sum[MS_W-1:0];
            if (x_sum[X_W] != x_sum[X_W-1])
                x_reg <= x_sum[X_W] ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}};
            else
                x_reg <= x_sum[X_W-1:0];
        end
    end

    // capture of unit results
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            unique case (cmd.op)
                DP_MUL_D:  lr_reg  <= mul_p[85:0];
                DP_MUL_N:  xsq_reg <= mul_p[86:0];
                DP_ROOT_C: c_reg   <= c_val;
                DP_ROOT_U: u_reg   <= root_q[15:0];
                DP_ROOT_T: t_reg   <= root_q[15:0];
                DP_ROOT_A: a_reg   <= root_q;
                DP_ROOT_B: b_reg   <= root_q;
                DP_DIV:    p_reg   <= p_val;
                default:   ;
            endcase
        end
        if (cmd.op == DP_WIDTH)
            w_reg <= w_val;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_FINISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_FINISH)
        begin
            ow_reg  <= w_reg;
            oc_reg  <= c_reg;
            oph_reg <= phase_c;
            op_reg  <= p_reg;
        end
    end

    smc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    smc_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .d     (root_d),
        .n     (root_n),
        .top   (root_top),
        .done  (root_done),
        .q     (root_q)
    );

    smc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q)
    );

    assign status.unit_done = mul_done || root_done || div_done;
    assign status.last      = last_reg;
    assign status.out_full  = out_valid_reg;

    assign out_valid       = out_valid_reg;
    assign stereo_width    = ow_reg;
    assign correlation     = oc_reg;
    assign phase_stability = oph_reg;
    assign pan             = op_reg;

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FINISH) |-> !out_valid_reg)
        else $error("result loaded while previous one pending");

    // only one arithmetic unit finishes at a time
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, root_done, div_done}))
        else $error("more than one unit finished together");

    // frame end leaves empty accumulators
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_FINISH) |=> (le_reg == '0 && re_reg == '0 && x_reg == '0))
        else $error("accumulators not cleared after frame end");
`endif

endmodule
`default_nettype wire

// ===== sv/smc_ctrl.sv =====
`default_nettype none
module smc_ctrl import smc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.op     = DP_NONE;
        cmd.start  = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_SQ_L;
            end
            ST_SQ_L:
            begin
                cmd.op     = DP_SQ_L;
                state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                cmd.op     = DP_SQ_R;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                cmd.op     = DP_CROSS;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op     = DP_ACC;
                state_next = status.last ? ST_MUL_D : ST_IDLE;
            end
            ST_MUL_D:
            begin
                cmd.op     = DP_MUL_D;
                cmd.start  = 1'b1;
                state_next = ST_MUL_D_W;
            end
            ST_MUL_D_W:
            begin
                cmd.op = DP_MUL_D;
                if (status.unit_done)
                    state_next = ST_MUL_N;
            end
            ST_MUL_N:
            begin
                cmd.op     = DP_MUL_N;
                cmd.start  = 1'b1;
                state_next = ST_MUL_N_W;
            end
            ST_MUL_N_W:
            begin
                cmd.op = DP_MUL_N;
                if (status.unit_done)
                    state_next = ST_ROOT_C;
            end
            ST_ROOT_C:
            begin
                cmd.op     = DP_ROOT_C;
                cmd.start  = 1'b1;
                state_next = ST_ROOT_C_W;
            end
            ST_ROOT_C_W:
            begin
                cmd.op = DP_ROOT_C;
                if (status.unit_done)
                    state_next = ST_ROOT_U;
            end
            ST_ROOT_U:
            begin
                cmd.op     = DP_ROOT_U;
                cmd.start  = 1'b1;
                state_next = ST_ROOT_U_W;
            end
            ST_ROOT_U_W:
            begin
                cmd.op = DP_ROOT_U;
                if (status.unit_done)
                    state_next = ST_ROOT_T;
            end
            ST_ROOT_T:
            begin
                cmd.op     = DP_ROOT_T;
                cmd.start  = 1'b1;
                state_next = ST_ROOT_T_W;
            end
            ST_ROOT_T_W:
            begin
                cmd.op = DP_ROOT_T;
                if (status.unit_done)
                    state_next = ST_ROOT_A;
            end
            ST_ROOT_A:
            begin
                cmd.op     = DP_ROOT_A;
                cmd.start  = 1'b1;
                state_next = ST_ROOT_A_W;
            end
            ST_ROOT_A_W:
            begin
                cmd.op = DP_ROOT_A;
                if (status.unit_done)
                    state_next = ST_ROOT_B;
            end
            ST_ROOT_B:
            begin
                cmd.op     = DP_ROOT_B;
                cmd.start  = 1'b1;
                state_next = ST_ROOT_B_W;
            end
            ST_ROOT_B_W:
            begin
                cmd.op = DP_ROOT_B;
                if (status.unit_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op     = DP_DIV;
                cmd.start  = 1'b1;
                state_next = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                cmd.op = DP_DIV;
                if (status.unit_done)
                    state_next = ST_WIDTH;
            end
            ST_WIDTH:
            begin
                cmd.op     = DP_WIDTH;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = DP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    // an accepted item always starts the product sequence
    a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SQ_L))
        else $error("accepted item did not start products");

    // a free output register lets the frame result leave at once
    a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && !status.out_full) |=> (state_reg == ST_IDLE))
        else $error("frame result held with free output register");
`endif

endmodule
`default_nettype wire

// ===== sv/stereo_correlation_meter_core.sv =====
// Channel | Signals                                      | Direction
// input   | in_valid, in_ready, left_sample, right_sample,| into the block
//         | last_in_frame                                |
// output  | out_valid, out_ready, stereo_width,          | out of the block
//         | correlation, phase_stability, pan            |
//
// An item is taken in at ST_IDLE, goes through the shared sample multiplier in ST_SQ_L,
// ST_SQ_R and ST_CROSS and updates the accumulators in ST_ACC.
// The item marked last then adds two wide products, three 16-bit and two 32-bit root
// searches, a divide, the width step and the output load.
// A waiting result lets the next frame's items in and stalls only the following frame end.
// rst_n clears the accumulators and all control state asynchronously.
`default_nettype none
module stereo_correlation_meter_core import smc_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SMP_W-1:0] left_sample,
    input  logic signed [SMP_W-1:0] right_sample,
    input  logic                    last_in_frame,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             stereo_width,
    output logic signed [15:0]      correlation,
    output logic [15:0]             phase_stability,
    output logic signed [15:0]      pan
);

    dp_cmd_t    cmd;
    dp_status_t status;

    smc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    smc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .last_in_frame   (last_in_frame),
        .out_ready       (out_ready),
        .status          (status),
        .out_valid       (out_valid),
        .stereo_width    (stereo_width),
        .correlation     (correlation),
        .phase_stability (phase_stability),
        .pan             (pan)
    );

endmodule
`default_nettype wire

// ===== tb/stereo_correlation_meter_core_tb.sv =====
`default_nettype none
module stereo_correlation_meter_core_tb;
    import smc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          RANDOM_ITEMS   = 580;
    localparam int          OVERLONG_LEN   = 100;
    localparam logic [42:0] LR_SAT         = {43{1'b1}};
    localparam logic [44:0] MS_SAT         = {45{1'b1}};
    localparam longint      X_HI           = (64'sd1 <<< 43) - 1;
    localparam longint      X_LO           = -(64'sd1 <<< 43);

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
        logic               drain;   // hold off until all results are in
    } pair_t;

    typedef struct {
        logic [15:0]        width;
        logic signed [15:0] corr;
        logic [15:0]        stab;
        logic signed [15:0] pan;
    } meter_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_in_frame;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        stereo_width;
    logic signed [15:0] correlation;
    logic [15:0]        phase_stability;
    logic signed [15:0] pan;

    pair_t  pair_q[$];
    meter_t meter_q[$];
    int     errors;
    int     stall_mode;     // in mode 0 the receiver idles more, in 1 the sender, in 2 neither
    int     idle_count;
    bit     in_taken;
    bit     stim_done;

    // running frame sums of the predictor
    logic [42:0] sum_ll;
    logic [42:0] sum_rr;
    logic [44:0] sum_mid;
    logic [44:0] sum_side;
    longint      sum_lr;

    stereo_correlation_meter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .last_in_frame   (last_in_frame),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stereo_width    (stereo_width),
        .correlation     (correlation),
        .phase_stability (phase_stability),
        .pan             (pan)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // largest q <= lim with q*q*den <= num
    function automatic longint ratio_root(input logic [127:0] den, input logic [127:0] num,
                                          input longint lim);
        longint lo;
        longint hi;
        longint q;
        logic [127:0] prod;
        lo = 0;
        hi = lim;
        while (lo < hi)
        begin
            q    = (lo + hi + 1) >>> 1;
            prod = den * 128'(q * q);
            if (prod <= num)
                lo = q;
            else
                hi = q - 1;
        end
        return lo;
    endfunction

    function automatic logic [44:0] sat45(input logic [44:0] acc, input logic [44:0] add,
                                          input logic [44:0] lim);
        logic [45:0] s;
        s = {1'b0, acc} + {1'b0, add};
        return (s > {1'b0, lim}) ? lim : s[44:0];
    endfunction

    // fold one pair into the frame sums; returns 1 with the meter reading at frame end
    function automatic bit meter_update(input pair_t p, output meter_t m);
        longint      l;
        longint      r;
        longint      x;
        longint      c;
        longint      pn;
        longint      t;
        longint      u;
        longint      w;
        longint      a;
        longint      b;
        logic [63:0] ax;
        l = longint'(p.left);
        r = longint'(p.right);
        sum_ll   = 43'(sat45(45'(sum_ll), 45'(l * l), 45'(LR_SAT)));
        sum_rr   = 43'(sat45(45'(sum_rr), 45'(r * r), 45'(LR_SAT)));
        sum_mid  = sat45(sum_mid,  45'((l + r) * (l + r)), MS_SAT);
        sum_side = sat45(sum_side, 45'((l - r) * (l - r)), MS_SAT);
        x = sum_lr + l * r;
        sum_lr = (x > X_HI) ? X_HI : ((x < X_LO) ? X_LO : x);
        m = '{default: '0};
        if (!p.last)
            return 1'b0;

        // correlation
        c = 0;
        if (sum_ll != 0 && sum_rr != 0)
        begin
            ax = (sum_lr < 0) ? 64'(-sum_lr) : 64'(sum_lr);
            c  = ratio_root(128'(sum_ll) * 128'(sum_rr), (128'(ax) * 128'(ax)) << 30, 32768);
            if (sum_lr < 0)
                c = -c;
            else if (c > 32767)
                c = 32767;
        end

        // width
        u = longint'(floor_sqrt(64'(32768 - c) << 13));
        if (sum_mid == 0)
            w = (sum_side != 0) ? longint'(W_MAX) : ((longint'(K072) * u) >>> 16);
        else if (52'(sum_side) >= 52'(sum_mid) * 52'd16)
            w = longint'(W_MAX);
        else
        begin
            t = ratio_root(128'(sum_mid), 128'(sum_side) << 28, 65535);
            w = (longint'(K072) * (t + u)) >>> 16;
        end
        if (w > longint'(W_MAX))
            w = longint'(W_MAX);

        // pan from the two levels
        a  = longint'(floor_sqrt(64'(sum_ll) << 20));
        b  = longint'(floor_sqrt(64'(sum_rr) << 20));
        pn = 0;
        if (a + b != 0)
        begin
            pn = ((b - a) * 32768) / (a + b);
            if (pn > 32767)
                pn = 32767;
            if (pn < -32767)
                pn = -32767;
        end

        m.width = 16'(w);
        m.corr  = 16'(c);
        m.stab  = 16'(c + 32768);
        m.pan   = 16'(pn);
        sum_ll   = '0;
        sum_rr   = '0;
        sum_mid  = '0;
        sum_side = '0;
        sum_lr   = 0;
        return 1'b1;
    endfunction

    function automatic void add_pair(input int l, input int r, input bit last, input bit drain);
        pair_t p;
        p.left  = 16'(l);
        p.right = 16'(r);
        p.last  = last;
        p.drain = drain;
        pair_q.insert(pair_q.size(), p);
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 64) - 32;
            default: return int'(16'($urandom));
        endcase
    endfunction

    // accepted pairs go through the predictor
    always @(posedge clk)
    begin
        meter_t m;
        pair_t  p;
        if (rst_n && in_valid && in_ready)
        begin
            p.left  = left_sample;
            p.right = right_sample;
            p.last  = last_in_frame;
            p.drain = 1'b0;
            if (meter_update(p, m))
                meter_q.insert(meter_q.size(), m);
            in_taken = 1'b1;
        end
    end

    // sender: next pair presented at the falling edge
    always @(negedge clk)
    begin
        bit send;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            send = pair_q.size() != 0;
            if (send && pair_q[0].drain && meter_q.size() != 0)
                send = 1'b0;
            if (send && stall_mode == 0 && $urandom_range(0, 99) < 20)
                send = 1'b0;
            if (send && stall_mode == 1 && $urandom_range(0, 99) < 51)
                send = 1'b0;
            if (send)
            begin
                left_sample   <= pair_q[0].left;
                right_sample  <= pair_q[0].right;
                last_in_frame <= pair_q[0].last;
                in_valid      <= 1'b1;
                void'(pair_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            case (stall_mode)
                0:       out_ready <= $urandom_range(0, 99) >= 51;
                1:       out_ready <= $urandom_range(0, 99) >= 20;
                default: out_ready <= 1'b1;
            endcase
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        meter_t m;
        if (rst_n && out_valid && out_ready)
        begin
            if (meter_q.size() == 0)
            begin
                $display("%0t: unexpected result width=%0d corr=%0d stab=%0d pan=%0d",
                         $time, stereo_width, correlation, phase_stability, pan);
                errors++;
            end
            else
            begin
                m = meter_q.pop_front();
                if (stereo_width !== m.width)
                begin
                    $display("%0t: stereo_width expected %0d got %0d", $time, m.width,
                             stereo_width);
                    errors++;
                end
                if (correlation !== m.corr)
                begin
                    $display("%0t: correlation expected %0d got %0d", $time, m.corr,
                             correlation);
                    errors++;
                end
                if (phase_stability !== m.stab)
                begin
                    $display("%0t: phase_stability expected %0d got %0d", $time, m.stab,
                             phase_stability);
                    errors++;
                end
                if (pan !== m.pan)
                begin
                    $display("%0t: pan expected %0d got %0d", $time, m.pan, pan);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int n;
        int len;
        int kind;
        int l;
        int r;
        errors        = 0;
        stall_mode    = 0;
        idle_count    = 0;
        in_taken      = 1'b0;
        stim_done     = 1'b0;
        sum_ll        = '0;
        sum_rr        = '0;
        sum_mid       = '0;
        sum_side      = '0;
        sum_lr        = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        left_sample   = '0;
        right_sample  = '0;
        last_in_frame = 1'b0;
        out_ready     = 1'b0;

        // directed frames: extremes, silent channels, empty mid, very wide, zero frame
        add_pair(32767, 32767, 1, 0);
        add_pair(-32768, -32768, 1, 0);
        add_pair(-32768, 32767, 1, 0);
        add_pair(32767, 0, 1, 0);
        add_pair(0, -32768, 1, 0);
        add_pair(0, 0, 1, 0);
        add_pair(1000, -1000, 0, 0);
        add_pair(-5, 5, 1, 0);
        add_pair(1, 0, 0, 0);
        add_pair(0, 1, 1, 0);
        add_pair(300, -290, 1, 0);
        add_pair(-1, -1, 0, 0);
        add_pair(32767, -32768, 1, 1);
        add_pair(20000, 10000, 0, 0);
        add_pair(-20000, -9000, 1, 0);
        // long full-scale frame in opposite phase
        for (int i = 0; i < OVERLONG_LEN; i++)
            add_pair(32767, -32768, i == OVERLONG_LEN - 1, 0);
        add_pair(-32768, -32768, 0, 0);
        add_pair(32767, 32767, 1, 0);

        // random frames, mostly short, often with related channels
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            kind = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
            begin
                l = rand_sample();
                case (kind)
                    0:       r = l;
                    1:       r = (l == -32768) ? 32767 : -l;
                    2:       r = l / 2 + $urandom_range(0, 200) - 100;
                    default: r = rand_sample();
                endcase
                add_pair(l, r, i == len - 1, i == 0 && $urandom_range(0, 15) == 0);
            end
            n += len;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idling pattern follows progress through the queue
        n = pair_q.size();
        while (pair_q.size() > (2 * n) / 3)
            @(posedge clk);
        stall_mode = 1;
        while (pair_q.size() > n / 3)
            @(posedge clk);
        stall_mode = 2;
        while (pair_q.size() != 0 || in_valid)
            @(posedge clk);
        while (meter_q.size() != 0)
            @(posedge clk);
        stim_done = 1'b1;
        repeat (300) @(posedge clk);

        if (meter_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, meter_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/smc_pkg.sv
sv/smc_mul.sv
sv/smc_root.sv
sv/smc_div.sv
sv/smc_datapath.sv
sv/smc_ctrl.sv
sv/stereo_correlation_meter_core.sv
tb/stereo_correlation_meter_core_tb.sv
